[design/sorted_per_key_member_lists_core_defines.svh]
// Assertion macros shared by the core.
`ifndef SORTED_PER_KEY_MEMBER_LISTS_CORE_DEFINES_SVH
`define SORTED_PER_KEY_MEMBER_LISTS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPKML_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPKML_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list core: next-cycle check failed");

`endif

[design/spkml_pkg.sv]
`timescale 1ns / 1ps
package spkml_pkg;

  localparam int unsigned NameW   = 40;
  localparam int unsigned CourseW = 9;
  localparam int unsigned CntW    = 6;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  localparam logic OpAdd  = 1'b0;
  localparam logic OpList = 1'b1;

  // Per-bucket bookkeeping word kept in the bucket memory.
  typedef struct packed {
    logic            dropped;
    logic [CntW-1:0] count;
  } meta_t;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StMeta  = 6'b000100,
    StShift = 6'b001000,
    StPlace = 6'b010000,
    StList  = 6'b100000
  } state_e;

endpackage

[design/sorted_per_key_member_lists_core.sv]
`timescale 1ns / 1ps
// Add item: the bucket word is read (StMeta), then each stored name greater than the new
// one moves up one entry per cycle (StShift) before the name and count are written
// (StPlace); a full bucket sets its dropped flag, and an unknown course is ignored.
// List item: the header is registered once the bucket word is read and the output slot is
// free, then one name per cycle while the sink takes them. One item is worked on at a time.
// After reset a clearing pass writes every bucket word before the first item is accepted.
`include "sorted_per_key_member_lists_core_defines.svh"
module sorted_per_key_member_lists_core #(
  parameter int unsigned NUM_BUCKETS     = 256,
  parameter int unsigned BUCKET_CAPACITY = 63
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [39:0] student_name, [48:40] course, [55:49] zero
  input  logic [spkml_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] operation
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [8:0] course_out, [14:9] member_count, [15] overflowed, [55:16] name_out
  output logic [spkml_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] is_header
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  localparam int unsigned NameDepth = NUM_BUCKETS * BUCKET_CAPACITY;
  localparam int unsigned AW = (NameDepth > 1) ? $clog2(NameDepth) : 1;
  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned NW = spkml_pkg::NameW;
  localparam int unsigned CW = spkml_pkg::CntW;
  localparam int unsigned MW = $bits(spkml_pkg::meta_t);
  localparam logic [CW-1:0] Cap = CW'(BUCKET_CAPACITY);

  spkml_pkg::state_e state_q, state_d;

  logic [BW-1:0] clr_idx_q, clr_idx_d;

  // Captured item.
  logic                           op_q;
  logic [NW-1:0]                  name_q;
  logic [spkml_pkg::CourseW-1:0]  course_q;
  logic                           valid_q;
  logic [BW-1:0]                  bkt_q;
  logic [AW-1:0]                  base_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] idx_q, idx_d;

  // Output register.
  logic                           out_valid_q, out_valid_d;
  logic                           out_hdr_q, out_hdr_d;
  logic [spkml_pkg::CourseW-1:0]  out_course_q, out_course_d;
  logic [CW-1:0]                  out_cnt_q, out_cnt_d;
  logic                           out_ovf_q, out_ovf_d;
  logic [NW-1:0]                  out_name_q, out_name_d;
  logic                           out_last_q, out_last_d;
  logic                           out_load;
  logic                           slot_free;

  logic accept;
  logic in_op;
  logic [NW-1:0] in_name;
  logic [spkml_pkg::CourseW-1:0] in_course;
  logic in_valid;
  logic [BW-1:0] in_bkt;

  // Memory ports.
  logic                  meta_we, meta_re;
  logic [BW-1:0]         meta_waddr;
  spkml_pkg::meta_t      meta_wdata, meta_rd;
  logic [MW-1:0]         meta_rdata;
  logic                  name_we, name_re;
  logic [AW-1:0]         name_waddr, name_raddr;
  logic [NW-1:0]         name_wdata, name_rdata;

  assign in_op     = s_axis_tuser_i;
  assign in_name   = s_axis_tdata_i[NW-1:0];
  assign in_course = s_axis_tdata_i[NW +: spkml_pkg::CourseW];
  assign in_valid  = (in_course != '0) && (32'(in_course) <= NUM_BUCKETS);
  assign in_bkt    = BW'(32'(in_course) - 32'd1);

  assign s_axis_tready_o = (state_q == spkml_pkg::StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign meta_rd         = spkml_pkg::meta_t'(meta_rdata);

  spkml_ram #(.Width(MW), .Depth(NUM_BUCKETS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (MW'(meta_wdata)),
    .re_i    (meta_re),
    .raddr_i (in_bkt),
    .rdata_o (meta_rdata)
  );

  spkml_ram #(.Width(NW), .Depth(NameDepth)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_waddr),
    .wdata_i (name_wdata),
    .re_i    (name_re),
    .raddr_i (name_raddr),
    .rdata_o (name_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    meta_re      = accept;
    meta_we      = 1'b0;
    meta_waddr   = bkt_q;
    meta_wdata   = '{dropped: drop_q, count: cnt_q + CW'(1)};
    name_we      = 1'b0;
    name_waddr   = base_q + AW'(pos_q);
    name_wdata   = name_q;
    name_re      = 1'b0;
    name_raddr   = base_q + AW'(pos_q - CW'(2));
    out_load     = 1'b0;
    out_hdr_d    = out_hdr_q;
    out_course_d = out_course_q;
    out_cnt_d    = out_cnt_q;
    out_ovf_d    = out_ovf_q;
    out_name_d   = out_name_q;
    out_last_d   = out_last_q;

    case (state_q)
      spkml_pkg::StClear: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx_q;
        meta_wdata = '0;
        clr_idx_d  = clr_idx_q + BW'(1);
        if (clr_idx_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = spkml_pkg::StIdle;
        end
      end
      spkml_pkg::StIdle: begin
        if (accept) begin
          state_d = spkml_pkg::StMeta;
        end
      end
      spkml_pkg::StMeta: begin
        cnt_d  = meta_rd.count;
        drop_d = meta_rd.dropped;
        if (op_q == spkml_pkg::OpAdd) begin
          if (!valid_q) begin
            state_d = spkml_pkg::StIdle;
          end else if (meta_rd.count >= Cap) begin
            meta_we    = 1'b1;
            meta_wdata = '{dropped: 1'b1, count: Cap};
            state_d    = spkml_pkg::StIdle;
          end else begin
            pos_d = meta_rd.count;
            if (meta_rd.count == '0) begin
              state_d = spkml_pkg::StPlace;
            end else begin
              name_re    = 1'b1;
              name_raddr = base_q + AW'(meta_rd.count - CW'(1));
              state_d    = spkml_pkg::StShift;
            end
          end
        end else if (slot_free) begin
          // Header of a listing; an unknown course reads as an empty bucket.
          out_load     = 1'b1;
          out_hdr_d    = 1'b1;
          out_course_d = course_q;
          out_cnt_d    = valid_q ? meta_rd.count : '0;
          out_ovf_d    = valid_q && meta_rd.dropped;
          out_name_d   = '0;
          out_last_d   = !valid_q || (meta_rd.count == '0);
          idx_d        = '0;
          if (valid_q && (meta_rd.count != '0)) begin
            name_re    = 1'b1;
            name_raddr = base_q;
            state_d    = spkml_pkg::StList;
          end else begin
            state_d = spkml_pkg::StIdle;
          end
        end
      end
      spkml_pkg::StShift: begin
        // name_rdata holds the entry just below the hole at pos_q; the entry
        // below that is fetched in the same cycle.
        name_re = (pos_q >= CW'(2));
        if (name_rdata > name_q) begin
          name_we    = 1'b1;
          name_wdata = name_rdata;
          pos_d      = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = spkml_pkg::StPlace;
          end
        end else begin
          state_d = spkml_pkg::StPlace;
        end
      end
      spkml_pkg::StPlace: begin
        name_we = 1'b1;
        meta_we = 1'b1;
        state_d = spkml_pkg::StIdle;
      end
      spkml_pkg::StList: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_hdr_d    = 1'b0;
          out_name_d   = name_rdata;
          out_last_d   = (idx_q + CW'(1) == cnt_q);
          if (idx_q + CW'(1) == cnt_q) begin
            state_d = spkml_pkg::StIdle;
          end else begin
            name_re    = 1'b1;
            name_raddr = base_q + AW'(idx_q + CW'(1));
            idx_d      = idx_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = spkml_pkg::StIdle;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spkml_pkg::StClear;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op;
      name_q   <= in_name;
      course_q <= in_course;
      valid_q  <= in_valid;
      bkt_q    <= in_bkt;
      base_q   <= AW'(32'(in_bkt) * BUCKET_CAPACITY);
    end
    cnt_q        <= cnt_d;
    drop_q       <= drop_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    out_hdr_q    <= out_hdr_d;
    out_course_q <= out_course_d;
    out_cnt_q    <= out_cnt_d;
    out_ovf_q    <= out_ovf_d;
    out_name_q   <= out_name_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_hdr_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {out_name_q, out_ovf_q, out_cnt_q, out_course_q};

  `SPKML_ASSERT_NOW(a_shift_pos, state_q == spkml_pkg::StShift,
                    (pos_q != '0) && (pos_q <= cnt_q) && (cnt_q < Cap))
  `SPKML_ASSERT_NOW(a_meta_count, (state_q == spkml_pkg::StMeta) && valid_q,
                    meta_rd.count <= Cap)
  `SPKML_ASSERT_NEXT(a_last_ends, out_load && out_last_d,
                     state_q == spkml_pkg::StIdle)

endmodule

[design/spkml_ram.sv]
`timescale 1ns / 1ps
module spkml_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[dv/spkml_roster_checker.sv]
`timescale 1ns / 1ps
module spkml_roster_checker
  import spkml_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS     = 256,
  parameter int unsigned BUCKET_CAPACITY = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tuser_i,
  input  logic                m_tlast_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic               is_header;
    logic [CourseW-1:0] course;
    logic [CntW-1:0]    count;
    logic               overflowed;
    logic [NameW-1:0]   name;
    logic               last;
  } roster_beat_t;

  logic [NameW-1:0] roster [NUM_BUCKETS][BUCKET_CAPACITY];
  logic [CntW-1:0]  headcount [NUM_BUCKETS];
  logic             dropped [NUM_BUCKETS];
  roster_beat_t     listing_q [$];
  int unsigned      mismatches;

  assign mismatches_o = mismatches;

  // Sorted insertion; an equal name lands after the names already stored.
  task automatic enroll(int unsigned b, logic [NameW-1:0] nm);
    int unsigned pos;
    pos = headcount[b];
    if (pos >= BUCKET_CAPACITY) begin
      dropped[b] = 1'b1;
      return;
    end
    while (pos > 0 && roster[b][pos-1] > nm) begin
      roster[b][pos] = roster[b][pos-1];
      pos--;
    end
    roster[b][pos] = nm;
    headcount[b] = headcount[b] + 1'b1;
  endtask

  task automatic list_course(logic [CourseW-1:0] crs);
    roster_beat_t beat;
    int unsigned  b;
    int unsigned  n;
    int unsigned  i;
    beat = '0;
    beat.is_header = 1'b1;
    beat.course = crs;
    // A course outside the bucket range lists as an empty, clean bucket.
    if (crs == 0 || crs > NUM_BUCKETS) begin
      beat.last = 1'b1;
      listing_q.push_back(beat);
      return;
    end
    b = crs - 1;
    n = headcount[b];
    beat.count = headcount[b];
    beat.overflowed = dropped[b];
    beat.last = (n == 0);
    listing_q.push_back(beat);
    for (i = 0; i < n; i++) begin
      beat.is_header = 1'b0;
      beat.name = roster[b][i];
      beat.last = (i + 1 == n);
      listing_q.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    roster_beat_t       got;
    roster_beat_t       want;
    logic [CourseW-1:0] crs;
    int unsigned        b;
    if (!rst_ni) begin
      for (b = 0; b < NUM_BUCKETS; b++) begin
        headcount[b] = '0;
        dropped[b] = 1'b0;
      end
      listing_q.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.is_header  = m_tuser_i;
        got.course     = m_tdata_i[CourseW-1:0];
        got.count      = m_tdata_i[CourseW +: CntW];
        got.overflowed = m_tdata_i[CourseW+CntW];
        got.name       = m_tdata_i[CourseW+CntW+1 +: NameW];
        got.last       = m_tlast_i;
        if (listing_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t unexpected item: hdr=%0d course=%0d cnt=%0d ovf=%0d name=%h last=%0d",
                     $time, got.is_header, got.course, got.count, got.overflowed,
                     got.name, got.last);
        end else begin
          want = listing_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%t mismatch: expected hdr=%0d course=%0d cnt=%0d ovf=%0d name=%h ",
                        "last=%0d, got hdr=%0d course=%0d cnt=%0d ovf=%0d name=%h last=%0d"},
                       $time, want.is_header, want.course, want.count, want.overflowed,
                       want.name, want.last, got.is_header, got.course, got.count,
                       got.overflowed, got.name, got.last);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        crs = s_tdata_i[NameW +: CourseW];
        if (s_tuser_i == OpAdd) begin
          if (crs != 0 && crs <= NUM_BUCKETS)
            enroll(crs - 1, s_tdata_i[NameW-1:0]);
        end else begin
          list_course(crs);
        end
      end
    end
    pending_o = listing_q.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import spkml_pkg::*;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned FillAdds    = 66;
  localparam int unsigned RandomItems = 170;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  int unsigned         roster_mismatches;
  int unsigned         pending;
  logic                no_idle = 1'b0;
  logic                hold_request = 1'b0;
  logic [NameW-1:0]    issued_names [$];
  logic [CourseW-1:0]  hot_courses [6] = '{9'd1, 9'd2, 9'd3, 9'd128, 9'd255, 9'd256};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_per_key_member_lists_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  spkml_roster_checker roster_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .mismatches_o (roster_mismatches),
    .pending_o    (pending)
  );

  task automatic offer(logic op, logic [NameW-1:0] nm, logic [CourseW-1:0] crs);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(InDataW-NameW-CourseW){1'b0}}, crs, nm};
    do @(posedge clk); while (!s_tready);
  endtask

  // Reusing an earlier name now and then exercises the equal-name ordering.
  function automatic logic [NameW-1:0] pick_name();
    logic [NameW-1:0] nm;
    if (issued_names.size() != 0 && $urandom_range(0, 3) == 0)
      return issued_names[$urandom_range(0, issued_names.size() - 1)];
    nm = NameW'({$urandom(), $urandom()});
    issued_names.push_back(nm);
    return nm;
  endfunction

  function automatic logic [CourseW-1:0] pick_course();
    if ($urandom_range(0, 9) == 0)
      return CourseW'($urandom_range(0, 511));
    return hot_courses[$urandom_range(0, 5)];
  endfunction

  // Sink side: a random hold-off before each item, or one long hold on request.
  initial begin
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold = LongHold;
        hold_request = 1'b0;
      end else if (no_idle) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 11);
      end
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle = 0;
      else
        idle++;
    end
    $display("sorted_per_key_member_lists_core regression: fail");
    $finish;
  end

  initial begin
    int unsigned i;
    logic        op;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty bucket, extreme names, equal names, both ends of the course range.
    offer(OpList, '0, 9'd1);
    offer(OpAdd, 40'h00_0000_0000, 9'd1);
    offer(OpAdd, 40'hFF_FFFF_FFFF, 9'd1);
    offer(OpAdd, 40'h62_6F62_0000, 9'd1);
    offer(OpAdd, 40'h61_6C69_6365, 9'd1);
    offer(OpAdd, 40'h62_6F62_0000, 9'd1);
    offer(OpList, 40'hFF_FFFF_FFFF, 9'd1);
    offer(OpAdd, 40'h5A_5A5A_5A5A, 9'd256);
    offer(OpAdd, 40'hA5_A5A5_A5A5, 9'd256);
    offer(OpList, '0, 9'd256);
    offer(OpAdd, 40'h11_2233_4455, 9'd0);
    offer(OpList, '0, 9'd0);
    offer(OpAdd, 40'h11_2233_4455, 9'd257);
    offer(OpList, '0, 9'd257);
    offer(OpAdd, 40'hFF_FFFF_FFFF, 9'd511);
    offer(OpList, 40'hFF_FFFF_FFFF, 9'd511);
    offer(OpList, '0, 9'd256);

    // Overfill one bucket so its count saturates and the dropped flag sticks.
    for (i = 0; i < FillAdds; i++)
      offer(OpAdd, pick_name(), 9'd2);
    offer(OpList, '0, 9'd2);

    for (i = 0; i < RandomItems; i++) begin
      if (i == 40)
        no_idle = 1'b1;
      if (i == 70)
        no_idle = 1'b0;
      if (i == 90)
        hold_request = 1'b1;
      if (i == 130) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      op = ($urandom_range(0, 3) == 0) ? OpList : OpAdd;
      if (i >= 90 && i < 96)
        op = OpList;
      offer(op, pick_name(), pick_course());
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (roster_mismatches == 0 && pending == 0)
      $display("sorted_per_key_member_lists_core regression: pass");
    else
      $display("sorted_per_key_member_lists_core regression: fail");
    $finish;
  end

endmodule
